### design/tagged_block_pool_allocator_defines.svh
// Assertion macros shared by the tagged block pool allocator modules.
`ifndef TAGGED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define TAGGED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TBPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define TBPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/tbpa_pkg.sv
// Package: types, constants and codes of the tagged block pool allocator.
package tbpa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int TAG_BITS   = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ALIGN_UNIT = 16;
  localparam int BS_W       = 17;
  localparam int BSE_W      = BS_W + 1;
  localparam int BYTES_W    = 23;
  localparam int OFF_W      = 22;
  localparam int ACC_W      = BYTES_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = CFG_IDX_W'(1);

  localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = BS_W'(16);
  localparam logic [CNT_W-1:0] POOL_RST       = CNT_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    FUNC_ALLOC_BLOCKS = 2'd0,
    FUNC_ALLOC_BYTES  = 2'd1,
    FUNC_FREE         = 2'd2,
    FUNC_FREE_ALL     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_BADSIZE  = 2'd2,
    ST_BADINDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_SCAN,
    S_FILL,
    S_FREE_CHK,
    S_FREE_REF,
    S_FREE_SCAN,
    S_CLR,
    S_DONE
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [CNT_W-1:0]   count;
    logic [BYTES_W-1:0] bytes;
    logic [IDX_W-1:0]   block_index;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [IDX_W-1:0]    first_block;
    logic [OFF_W-1:0]    byte_offset;
    logic [TAG_BITS-1:0] tag;
  } out_item_t;

  typedef struct packed {
    logic [BSE_W-1:0] blk_bytes;
    logic [CNT_W-1:0] pool_n;
  } cfg_t;

  typedef struct packed {
    logic    ld_req;
    logic    div_step;
    logic    scan_init;
    logic    scan_step;
    logic    fill_step;
    logic    free_rd;
    logic    free_ref;
    logic    free_step;
    logic    clr_all;
    logic    res_load;
    logic    res_grant;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic div_stop;
    logic need_bad;
    logic scan_hit;
    logic scan_last;
    logic fill_last;
    logic idx_bad;
    logic ref_zero;
    logic free_match;
    logic free_end;
  } sts_t;

endpackage

### design/tagged_block_pool_allocator.sv
// Tagged block pool allocator: configuration registers, controller and datapath.
//
// A request is taken when start is high and busy is low; busy stays high until the result
// is ready. The result is shown for one cycle with out_valid and cannot be held off, so the
// receiver must take it on that cycle. Requests walk the tag table one block per cycle:
// allocate by count scans the pool in first-fit order for a free run of count blocks and
// stamps the run with a new tag; allocate by bytes first divides bytes by the block size
// by repeated addition; free checks the index, reads the tag of that block and frees the
// run that carries it up to the first block with another tag or the pool end; a free block
// or an index outside the pool ends it early; free all frees every block. Configuration
// writes are taken at any time but belong between requests.
`include "tagged_block_pool_allocator_defines.svh"

module tagged_block_pool_allocator import tbpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [BS_W-1:0]  block_size_r;
  logic [CNT_W-1:0] blocks_in_use_r;
  logic [BSE_W-1:0] bs_round;
  cfg_t             cfg;
  cmd_t             cmd;
  sts_t             sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r    <= BLOCK_SIZE_RST;
      blocks_in_use_r <= POOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE:    block_size_r    <= cfg_wdata[BS_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_wdata[CNT_W-1:0];
        default:           block_size_r    <= block_size_r;
      endcase
    end
  end

  assign bs_round = ({1'b0, block_size_r} + BSE_W'(ALIGN_UNIT - 1)) & ~BSE_W'(ALIGN_UNIT - 1);

  always_comb begin
    cfg.blk_bytes = (block_size_r == '0) ? BSE_W'(ALIGN_UNIT) : bs_round;
    if (blocks_in_use_r == '0) begin
      cfg.pool_n = CNT_W'(1);
    end else if (blocks_in_use_r > CNT_W'(MAX_BLOCKS)) begin
      cfg.pool_n = CNT_W'(MAX_BLOCKS);
    end else begin
      cfg.pool_n = blocks_in_use_r;
    end
  end

  tbpa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_item.func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  tbpa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `TBPA_ASSERT(a_one_cycle_strobe, out_valid |=> !out_valid, "result strobe held two cycles")
  `TBPA_ASSERT(a_accept_no_result, (start && !busy) |=> !out_valid, "result too soon after transfer")
  `TBPA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule

### design/tbpa_ctrl.sv
// Controller: request sequencing state machine of the allocator.
module tbpa_ctrl import tbpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  func_t in_func,
  input  sts_t  sts,
  output cmd_t  cmd,
  output logic  busy
);

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    grant_r, grant_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
      grant_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      grant_r <= grant_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    grant_nxt = grant_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          st_nxt    = ST_OK;
          grant_nxt = 1'b0;
          case (in_func)
            FUNC_ALLOC_BLOCKS: state_nxt = S_CHECK;
            FUNC_ALLOC_BYTES:  state_nxt = S_DIV;
            FUNC_FREE:         state_nxt = S_FREE_CHK;
            default:           state_nxt = S_CLR;
          endcase
        end
      end
      S_DIV: begin
        if (sts.div_stop) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.need_bad) begin
          st_nxt    = ST_BADSIZE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          state_nxt = S_FILL;
        end else if (sts.scan_last) begin
          st_nxt    = ST_NOSPACE;
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        if (sts.fill_last) begin
          grant_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FREE_CHK: begin
        if (sts.idx_bad) begin
          st_nxt    = ST_BADINDEX;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FREE_REF;
        end
      end
      S_FREE_REF: begin
        state_nxt = sts.ref_zero ? S_DONE : S_FREE_SCAN;
      end
      S_FREE_SCAN: begin
        if (!sts.free_match || sts.free_end) state_nxt = S_DONE;
      end
      S_CLR:  state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.res_status = st_r;
    cmd.res_grant  = grant_r;
    case (state_r)
      S_IDLE:      cmd.ld_req    = start;
      S_DIV:       cmd.div_step  = !sts.div_stop;
      S_CHECK:     cmd.scan_init = !sts.need_bad;
      S_SCAN:      cmd.scan_step = 1'b1;
      S_FILL:      cmd.fill_step = 1'b1;
      S_FREE_CHK:  cmd.free_rd   = !sts.idx_bad;
      S_FREE_REF:  cmd.free_ref  = 1'b1;
      S_FREE_SCAN: cmd.free_step = 1'b1;
      S_CLR:       cmd.clr_all   = 1'b1;
      S_DONE:      cmd.res_load  = 1'b1;
      default:     cmd.ld_req    = 1'b0;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### design/tbpa_dp.sv
// Datapath: tag table, valid bits, tag counter, size division and result register.
`include "tagged_block_pool_allocator_defines.svh"

module tbpa_dp import tbpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [TAG_BITS-1:0] mem [MAX_BLOCKS];
  logic [TAG_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]    rd_addr;

  logic [MAX_BLOCKS-1:0] valid_r;
  logic [TAG_BITS-1:0]   ctr_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic [TAG_BITS-1:0]   ref_r;
  logic [CNT_W-1:0]      need_r;
  logic [CNT_W-1:0]      run_r;
  logic [BYTES_W-1:0]    bytes_r;
  logic [ACC_W-1:0]      acc_r;
  logic [IDX_W-1:0]      ptr_r;
  logic [IDX_W-1:0]      end_r;
  logic [IDX_W-1:0]      start_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic [TAG_BITS-1:0]    tag_inc;
  logic [TAG_BITS-1:0]    tag_new;
  logic [CNT_W-1:0]       ptr_ext;
  logic [CNT_W-1:0]       ptr_inc;
  logic [CNT_W-1:0]       run_inc;
  logic [CNT_W-1:0]       start_calc;
  logic                   cur_free;
  logic [IDX_W+BSE_W-1:0] prod;

  assign tag_inc    = ctr_r + TAG_BITS'(1);
  assign tag_new    = (tag_inc == '0) ? TAG_BITS'(1) : tag_inc;
  assign ptr_ext    = {1'b0, ptr_r};
  assign ptr_inc    = ptr_ext + CNT_W'(1);
  assign run_inc    = run_r + CNT_W'(1);
  assign start_calc = ptr_inc - need_r;
  assign cur_free   = !valid_r[ptr_r];
  assign prod       = start_r * cfg.blk_bytes;
  assign rd_addr    = (cmd.free_rd || cmd.free_ref) ? ptr_r : ptr_inc[IDX_W-1:0];

  always_comb begin
    sts.div_stop   = (acc_r >= {1'b0, bytes_r}) || (need_r > cfg.pool_n);
    sts.need_bad   = (need_r == '0) || (need_r > cfg.pool_n);
    sts.scan_hit   = cur_free && (run_inc == need_r);
    sts.scan_last  = (ptr_inc == cfg.pool_n);
    sts.fill_last  = (ptr_r == end_r);
    sts.idx_bad    = (ptr_ext >= cfg.pool_n);
    sts.ref_zero   = cur_free || (rd_data_r == '0);
    sts.free_match = !cur_free && (rd_data_r == ref_r);
    sts.free_end   = (ptr_inc >= cfg.pool_n);
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      mem[ptr_r] <= tag_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_load;
      if (cmd.clr_all) begin
        valid_r <= '0;
      end else if (cmd.fill_step) begin
        valid_r[ptr_r] <= 1'b1;
      end else if (cmd.free_step && sts.free_match) begin
        valid_r[ptr_r] <= 1'b0;
      end
      if (cmd.scan_step && sts.scan_hit) begin
        ctr_r <= tag_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      need_r  <= (in_item.func == FUNC_ALLOC_BYTES) ? '0 : in_item.count;
      bytes_r <= in_item.bytes;
      acc_r   <= '0;
      ptr_r   <= in_item.block_index;
    end
    if (cmd.div_step) begin
      acc_r  <= acc_r + ACC_W'(cfg.blk_bytes);
      need_r <= need_r + CNT_W'(1);
    end
    if (cmd.scan_init) begin
      ptr_r <= '0;
      run_r <= '0;
    end
    if (cmd.scan_step) begin
      if (sts.scan_hit) begin
        start_r <= start_calc[IDX_W-1:0];
        ptr_r   <= start_calc[IDX_W-1:0];
        end_r   <= ptr_r;
        tag_r   <= tag_new;
      end else begin
        run_r <= cur_free ? run_inc : '0;
        ptr_r <= ptr_inc[IDX_W-1:0];
      end
    end
    if (cmd.fill_step) begin
      ptr_r <= ptr_inc[IDX_W-1:0];
    end
    if (cmd.free_ref) begin
      ref_r <= rd_data_r;
    end
    if (cmd.free_step && sts.free_match) begin
      ptr_r <= ptr_inc[IDX_W-1:0];
    end
    if (cmd.res_load) begin
      out_item_r.status <= cmd.res_status;
      if (cmd.res_grant) begin
        out_item_r.first_block <= start_r;
        out_item_r.byte_offset <= prod[OFF_W-1:0];
        out_item_r.tag         <= tag_r;
      end else begin
        out_item_r.first_block <= '0;
        out_item_r.byte_offset <= '0;
        out_item_r.tag         <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `TBPA_ASSERT(a_fill_in_pool, cmd.fill_step |-> (ptr_ext < cfg.pool_n), "fill past pool end")
  `TBPA_ASSERT(a_tag_nonzero, cmd.fill_step |-> (tag_r != '0), "zero tag stamped on a run")
  `TBPA_ASSERT(a_clear_all, cmd.clr_all |=> (valid_r == '0), "free all left blocks owned")

endmodule
